// ----- rtl/samc_pkg.sv -----
// shared types and constants of the sail angle and mode controller
package samc_pkg;

   // angle constants, Q4.11 radians
   localparam logic signed [15:0] ANG_PI      = 16'sd6434;
   localparam logic signed [15:0] ANG_TWO_PI  = 16'sd12868;
   localparam logic signed [15:0] ANG_HALF_PI = 16'sd3217;
   // 0.5 m/s in Q8.8
   localparam logic [15:0] LOW_WIND = 16'd128;

   // operation codes
   localparam logic [1:0] OP_PLAIN   = 2'd0;
   localparam logic [1:0] OP_STAB    = 2'd1;
   localparam logic [1:0] OP_REVERSE = 2'd2;

   // register indexes
   localparam logic [2:0] REG_AOA_OPTIMAL     = 3'd0;
   localparam logic [2:0] REG_SWITCH_POINT    = 3'd1;
   localparam logic [2:0] REG_HALF_HYST       = 3'd2;
   localparam logic [2:0] REG_SPIN_WIND_LIMIT = 3'd3;
   localparam logic [2:0] REG_RED_WIND_LIMIT  = 3'd4;
   localparam logic [2:0] REG_DRAG_OFFSET     = 3'd5;
   localparam logic [2:0] REG_SWITCH_DELAY    = 3'd6;

   // attack angle quotient width; the quotient never exceeds aoa_optimal
   localparam int QUOT_W = 13;

   typedef struct packed {
      logic signed [15:0] wind_angle;
      logic [15:0]        wind_speed;
      logic [1:0]         operation;
   } req_payload_type;

   typedef struct packed {
      logic signed [13:0] sail_angle;
      logic               mode_used;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  reg_index;
      logic [15:0] wdata;
   } csr_payload_type;

   typedef struct packed {
      logic [12:0] aoa_optimal;
      logic [12:0] switch_point;
      logic [11:0] half_hysteresis;
      logic [15:0] spinnaker_wind_limit;
      logic [15:0] reduction_wind_limit;
      logic [12:0] drag_offset;
      logic [15:0] switch_delay_ticks;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [15:0] speed;
   } att_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] value;
   } att_rsp_type;

endpackage

// ----- rtl/samc_chan_if.sv -----
// valid/ready channel carrying one payload item
interface samc_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/sail_angle_mode_controller.sv -----
// sail angle and mode controller: sequencer, mode state and output register
//
// req_ch takes one wind sample (wind_angle Q4.11 rad, wind_speed Q8.8 m/s,
// operation); rsp_ch returns one item per sample: sail_angle Q2.11 rad in
// [-pi, pi) and mode_used (0 wing, 1 spinnaker). csr_ch writes the seven
// configuration registers by index; it is always ready. The user must write it
// only while no sample is in flight; the block itself does not enforce this.
// A sample is worked on by a small sequencer: wrap steps bring the angle to
// [-pi, pi), a decide step picks the mode and updates the mode state, and
// when the wing attack angle is needed the shared attack unit runs. Without
// reduction it returns aoa_optimal; at or above the reduction wind limit it
// runs three multiplies, a rounding add and a 13 step restoring division.
// A final step forms the result. req ready is high only while the sequencer
// is idle, so a new sample is taken only after the previous one has left it.
// The result sits in an output register, so the next sample is taken while
// it waits; a stalled receiver holds the sequencer in its last step.
// Reset (synchronous) restores the register defaults, wing mode and a zero
// dwell counter, and drops any pending item.
module sail_angle_mode_controller (
   input  logic       clock,
   input  logic       reset,
   samc_chan_if.sink   req_ch,
   samc_chan_if.source rsp_ch,
   samc_chan_if.sink   csr_ch
);
   import samc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WRAP   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_ATTACK = 3'd3;
   localparam logic [2:0] ST_FINAL  = 3'd4;

   cfg_type     cfg;
   att_req_type att_req;
   att_rsp_type att_rsp;

   logic [2:0]         state_ff, state_in;
   logic signed [15:0] ang_ff, ang_in;
   logic [15:0]        speed_ff, speed_in;
   logic [1:0]         op_ff, op_in;
   logic signed [15:0] base_ff, base_in;
   logic               add_att_ff, add_att_in;
   logic               negate_ff, negate_in;
   logic               mode_ff, mode_in;
   logic [QUOT_W-1:0]  att_ff, att_in;
   logic               sail_mode_ff, sail_mode_in;
   logic [15:0]        dwell_ff, dwell_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [13:0] rsp_angle_ff, rsp_angle_in;
   logic               rsp_mode_ff, rsp_mode_in;

   logic               req_accept;
   logic               neg;
   logic signed [15:0] abs_ang;
   logic signed [15:0] mag_s;
   logic signed [15:0] half_s;
   logic signed [15:0] sp_s, h_s;
   logic signed [15:0] lo1, lo2, hi1, hi2, rev_lim;
   logic [15:0]        dwell_inc;
   logic               exceeds;
   logic               m;
   logic signed [15:0] gamma, vsum, wrapped;

   samc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   samc_attack u_attack (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .att_req (att_req),
      .att_rsp (att_rsp)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.payload.sail_angle = rsp_angle_ff;
   assign rsp_ch.payload.mode_used  = rsp_mode_ff;

   // magnitude and sign of the wrapped angle, zero counts as positive
   assign neg     = ang_ff[15];
   assign abs_ang = neg ? -ang_ff : ang_ff;
   assign mag_s   = {3'd0, abs_ang[12:0]};
   assign half_s  = {4'd0, abs_ang[12:1]};

   assign sp_s    = {3'd0, cfg.switch_point};
   assign h_s     = {4'd0, cfg.half_hysteresis};
   assign lo1     = sp_s - h_s;
   assign lo2     = sp_s - (h_s <<< 1);
   assign hi1     = sp_s + h_s;
   assign hi2     = sp_s + (h_s <<< 1);
   assign rev_lim = ANG_PI - sp_s;

   // saturating dwell count
   assign dwell_inc = (dwell_ff == 16'hFFFF) ? dwell_ff : dwell_ff + 16'd1;
   assign exceeds   = dwell_inc > cfg.switch_delay_ticks;

   // result: gamma with sign applied, then one wrap correction
   assign gamma   = base_ff + (add_att_ff ? $signed({3'd0, att_ff}) : 16'sd0);
   assign vsum    = negate_ff ? -gamma : gamma;

   always_comb begin
      priority if (vsum >= ANG_PI) begin
         wrapped = vsum - ANG_TWO_PI;
      end else if (vsum < -ANG_PI) begin
         wrapped = vsum + ANG_TWO_PI;
      end else begin
         wrapped = vsum;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ang_in       = ang_ff;
      speed_in     = speed_ff;
      op_in        = op_ff;
      base_in      = base_ff;
      add_att_in   = add_att_ff;
      negate_in    = negate_ff;
      mode_in      = mode_ff;
      att_in       = att_ff;
      sail_mode_in = sail_mode_ff;
      dwell_in     = dwell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_angle_in = rsp_angle_ff;
      rsp_mode_in  = rsp_mode_ff;
      att_req.start = 1'b0;
      att_req.speed = speed_ff;
      m = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ang_in   = req_ch.payload.wind_angle;
               speed_in = req_ch.payload.wind_speed;
               op_in    = req_ch.payload.operation;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            priority if (ang_ff >= ANG_PI) begin
               ang_in = ang_ff - ANG_TWO_PI;
            end else if (ang_ff < -ANG_PI) begin
               ang_in = ang_ff + ANG_TWO_PI;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (op_ff >= OP_REVERSE) begin
               priority if (speed_ff < LOW_WIND) begin
                  base_in    = ANG_HALF_PI;
                  add_att_in = 1'b0;
                  negate_in  = 1'b0;
                  mode_in    = 1'b1;
               end else if (mag_s < rev_lim || speed_ff > cfg.spinnaker_wind_limit) begin
                  base_in    = ANG_PI - mag_s;
                  add_att_in = 1'b1;
                  negate_in  = !neg;
                  mode_in    = 1'b0;
               end else begin
                  base_in    = ANG_HALF_PI;
                  add_att_in = 1'b0;
                  negate_in  = !neg;
                  mode_in    = 1'b1;
               end
            end else if (speed_ff == 16'd0) begin
               base_in    = 16'sd0;
               add_att_in = 1'b0;
               negate_in  = 1'b0;
               mode_in    = 1'b0;
            end else begin
               if (op_ff == OP_STAB) begin
                  if (speed_ff > cfg.spinnaker_wind_limit) begin
                     m = 1'b0;
                  end else begin
                     if (!sail_mode_ff) begin
                        priority if (mag_s <= lo2) begin
                           sail_mode_in = 1'b1;
                           dwell_in     = 16'd0;
                        end else if (mag_s < lo1) begin
                           if (exceeds) begin
                              sail_mode_in = 1'b1;
                              dwell_in     = 16'd0;
                           end else begin
                              dwell_in = dwell_inc;
                           end
                        end else begin
                           dwell_in = dwell_ff;
                        end
                     end else begin
                        priority if (mag_s > hi2) begin
                           sail_mode_in = 1'b0;
                           dwell_in     = 16'd0;
                        end else if (mag_s > hi1) begin
                           if (exceeds) begin
                              sail_mode_in = 1'b0;
                              dwell_in     = 16'd0;
                           end else begin
                              dwell_in = dwell_inc;
                           end
                        end else begin
                           dwell_in = dwell_ff;
                        end
                     end
                     m = sail_mode_in;
                  end
               end else begin
                  m = (mag_s < sp_s) && (speed_ff < cfg.spinnaker_wind_limit);
                  sail_mode_in = m;
               end
               if (!m) begin
                  base_in    = mag_s - ANG_PI;
                  add_att_in = 1'b1;
               end else begin
                  base_in    = half_s - $signed({3'd0, cfg.drag_offset});
                  add_att_in = 1'b0;
               end
               negate_in = neg;
               mode_in   = m;
            end
            if (add_att_in) begin
               att_req.start = 1'b1;
               state_in      = ST_ATTACK;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_ATTACK: begin
            if (att_rsp.done) begin
               att_in   = att_rsp.value;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = wrapped[13:0];
               rsp_mode_in  = mode_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sail_mode_ff <= 1'b0;
         dwell_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sail_mode_ff <= sail_mode_in;
         dwell_ff     <= dwell_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ang_ff       <= ang_in;
      speed_ff     <= speed_in;
      op_ff        <= op_in;
      base_ff      <= base_in;
      add_att_ff   <= add_att_in;
      negate_ff    <= negate_in;
      mode_ff      <= mode_in;
      att_ff       <= att_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_mode_ff  <= rsp_mode_in;
   end

`ifndef SYNTHESIS
   // a new sample is taken only after the previous one has left the sequencer
   assert property (@(posedge clock) disable iff (reset) req_accept |=> !req_ch.ready)
      else $error("sample accepted while sequencer busy");

   // the attack unit reports only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      att_rsp.done |-> state_ff == ST_ATTACK)
      else $error("attack result with no waiting sample");

   // a delivered angle is always wrapped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_angle_ff >= -ANG_PI) && (rsp_angle_ff < ANG_PI))
      else $error("sail angle out of range");

   // the dwell counter only steps up by one or clears
   assert property (@(posedge clock) disable iff (reset)
      (dwell_ff != $past(dwell_ff)) |-> (dwell_ff == 16'd0) ||
         (dwell_ff == $past(dwell_ff) + 16'd1))
      else $error("dwell counter jumped");
`endif
endmodule

// ----- rtl/samc_csr.sv -----
// configuration register file
module samc_csr (
   input  logic            clock,
   input  logic            reset,
   samc_chan_if.sink       csr_ch,
   output samc_pkg::cfg_type cfg
);
   import samc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.payload.reg_index)
            REG_AOA_OPTIMAL:     cfg_in.aoa_optimal = csr_ch.payload.wdata[12:0];
            REG_SWITCH_POINT:    cfg_in.switch_point = csr_ch.payload.wdata[12:0];
            REG_HALF_HYST:       cfg_in.half_hysteresis = csr_ch.payload.wdata[11:0];
            REG_SPIN_WIND_LIMIT: cfg_in.spinnaker_wind_limit = csr_ch.payload.wdata;
            REG_RED_WIND_LIMIT:  cfg_in.reduction_wind_limit = csr_ch.payload.wdata;
            REG_DRAG_OFFSET:     cfg_in.drag_offset = csr_ch.payload.wdata[12:0];
            REG_SWITCH_DELAY:    cfg_in.switch_delay_ticks = csr_ch.payload.wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aoa_optimal          <= 13'd1287;
         cfg_ff.switch_point         <= 13'd4289;
         cfg_ff.half_hysteresis      <= 12'd107;
         cfg_ff.spinnaker_wind_limit <= 16'd2560;
         cfg_ff.reduction_wind_limit <= 16'd1536;
         cfg_ff.drag_offset          <= 13'd0;
         cfg_ff.switch_delay_ticks   <= 16'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ----- rtl/samc_attack.sv -----
// attack angle unit: shared multiplier and restoring divider, one step a cycle
module samc_attack (
   input  logic                  clock,
   input  logic                  reset,
   input  samc_pkg::cfg_type     cfg,
   input  samc_pkg::att_req_type att_req,
   output samc_pkg::att_rsp_type att_rsp
);
   import samc_pkg::*;

   localparam logic [2:0] A_IDLE    = 3'd0;
   localparam logic [2:0] A_MUL_DEN = 3'd1;
   localparam logic [2:0] A_MUL_LL  = 3'd2;
   localparam logic [2:0] A_MUL_NUM = 3'd3;
   localparam logic [2:0] A_ADD     = 3'd4;
   localparam logic [2:0] A_DIV     = 3'd5;
   localparam logic [2:0] A_DONE    = 3'd6;

   localparam logic [3:0] LAST_STEP = 4'(QUOT_W - 1);

   logic [2:0]        state_ff, state_in;
   logic [15:0]       speed_ff, speed_in;
   logic [31:0]       den_ff, den_in;
   logic [31:0]       sq_ff, sq_in;
   logic [45:0]       rem_ff, rem_in;
   logic [43:0]       dvs_ff, dvs_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [31:0] mul_a;
   logic [15:0] mul_b;
   logic [47:0] mul_out;
   logic [46:0] diff;

   // one shared multiplier
   always_comb begin
      unique case (state_ff)
         A_MUL_DEN: begin
            mul_a = {16'd0, speed_ff};
            mul_b = speed_ff;
         end
         A_MUL_LL: begin
            mul_a = {16'd0, cfg.reduction_wind_limit};
            mul_b = cfg.reduction_wind_limit;
         end
         A_MUL_NUM: begin
            mul_a = sq_ff;
            mul_b = {3'd0, cfg.aoa_optimal};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 16'd0;
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;
   assign diff = {1'b0, rem_ff} - {3'd0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      speed_in = speed_ff;
      den_in   = den_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (att_req.start) begin
               speed_in = att_req.speed;
               if (att_req.speed < cfg.reduction_wind_limit || att_req.speed == 16'd0) begin
                  quot_in  = cfg.aoa_optimal;
                  state_in = A_DONE;
               end else begin
                  state_in = A_MUL_DEN;
               end
            end
         end
         A_MUL_DEN: begin
            den_in   = mul_out[31:0];
            state_in = A_MUL_LL;
         end
         A_MUL_LL: begin
            sq_in    = mul_out[31:0];
            state_in = A_MUL_NUM;
         end
         A_MUL_NUM: begin
            rem_in   = {1'b0, mul_out[44:0]};
            state_in = A_ADD;
         end
         A_ADD: begin
            // add half the divisor so the quotient rounds halves up
            rem_in   = rem_ff + {15'd0, den_ff[31:1]};
            dvs_in   = {den_ff, 12'd0};
            cnt_in   = LAST_STEP;
            quot_in  = '0;
            state_in = A_DIV;
         end
         A_DIV: begin
            if (!diff[46]) begin
               rem_in = diff[45:0];
            end
            quot_in = {quot_ff[QUOT_W-2:0], ~diff[46]};
            dvs_in  = {1'b0, dvs_ff[43:1]};
            cnt_in  = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   assign att_rsp.done  = (state_ff == A_DONE);
   assign att_rsp.value = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      speed_ff <= speed_in;
      den_ff   <= den_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      cnt_ff   <= cnt_in;
      quot_ff  <= quot_in;
   end
endmodule
